@@ hdl/pcg_pkg.sv @@
`default_nettype none

package pcg_pkg;

	// Counter widths of the channel
	localparam int COUNT_WIDTH    = 16;
	localparam int PRESCALE_WIDTH = 8;

	// Fixed widths of the register file
	localparam int DIV_LOG2_W    = 4;
	localparam int PRESCALE_K_W  = 8;
	localparam int PERIOD_CFG_W  = 17;
	localparam int ACTIVE_CFG_W  = 16;
	localparam int SRC_DIV_W     = 8;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 17;
	localparam int STREAM_W      = 8;

	// Width that holds both the period register and 2**COUNT_WIDTH
	localparam int CMP_W = (COUNT_WIDTH + 1 > PERIOD_CFG_W) ? COUNT_WIDTH + 1 : PERIOD_CFG_W;

	localparam logic [DIV_LOG2_W-1:0] DIV_LOG2_MAX = DIV_LOG2_W'(8);

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DIV_M_LOG2     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE_K     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BYPASS_MODE    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_CYCLES  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEN     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HIGH    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_ENABLE = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_GATE     = 3'd7;

	typedef struct packed {
		logic [DIV_LOG2_W-1:0]   div_m_log2;
		logic [PRESCALE_K_W-1:0] prescale_k;
		logic                    bypass_mode;
		logic [PERIOD_CFG_W-1:0] period_cycles;
		logic [ACTIVE_CFG_W-1:0] active_len;
		logic                    active_high;
		logic                    channel_enable;
		logic                    clock_gate;
	} pcg_cfg_t;

	typedef struct packed {
		logic period_start;
		logic pwm_level;
	} pcg_result_t;

endpackage

`default_nettype wire

@@ hdl/pcg_core.sv @@
`default_nettype none

// Channel counters: source divider, prescaler, period counter, bypass phase.
module pcg_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pcg_pkg::pcg_cfg_t  cfg,
	input  wire logic               accept,
	input  wire logic               tick,
	output pcg_pkg::pcg_result_t    result
);

	logic [pcg_pkg::SRC_DIV_W-1:0]      src_q, src_d;
	logic [pcg_pkg::PRESCALE_WIDTH-1:0] pre_q, pre_d;
	logic [pcg_pkg::COUNT_WIDTH-1:0]    per_cnt_q, per_cnt_d;
	logic                               phase_q, phase_d;

	logic                               run;
	logic                               step;
	logic [pcg_pkg::DIV_LOG2_W-1:0]     lg;
	logic [pcg_pkg::SRC_DIV_W:0]        dlim_w;
	logic [pcg_pkg::SRC_DIV_W-1:0]      dlim;
	logic                               divided;
	logic [pcg_pkg::PRESCALE_WIDTH-1:0] k;
	logic                               scaled;
	logic [pcg_pkg::CMP_W-1:0]          per_ext, per_max, per, per_m1, nxt;
	logic [pcg_pkg::COUNT_WIDTH-1:0]    act, act_eff;
	logic                               wrap;

	assign run  = cfg.clock_gate & cfg.channel_enable;
	assign step = accept & tick & run;

	always_comb begin
		// divider limit 2**lg - 1, exponent saturated at eight
		lg      = (cfg.div_m_log2 > pcg_pkg::DIV_LOG2_MAX) ? pcg_pkg::DIV_LOG2_MAX
			: cfg.div_m_log2;
		dlim_w  = ((pcg_pkg::SRC_DIV_W+1)'(1) << lg) - (pcg_pkg::SRC_DIV_W+1)'(1);
		dlim    = dlim_w[pcg_pkg::SRC_DIV_W-1:0];
		divided = (src_q >= dlim);

		k      = pcg_pkg::PRESCALE_WIDTH'(cfg.prescale_k);
		scaled = (pre_q >= k);

		// effective period: zero reads as one, saturate at 2**COUNT_WIDTH
		per_ext = pcg_pkg::CMP_W'(cfg.period_cycles);
		per_max = pcg_pkg::CMP_W'(1) << pcg_pkg::COUNT_WIDTH;
		if (per_ext == '0) begin
			per = pcg_pkg::CMP_W'(1);
		end else if (per_ext > per_max) begin
			per = per_max;
		end else begin
			per = per_ext;
		end
		per_m1 = per - pcg_pkg::CMP_W'(1);
		nxt    = pcg_pkg::CMP_W'(per_cnt_q) + pcg_pkg::CMP_W'(1);
		wrap   = (nxt >= per);

		src_d     = src_q;
		pre_d     = pre_q;
		per_cnt_d = per_cnt_q;
		phase_d   = phase_q;
		result.period_start = 1'b0;

		if (step) begin
			src_d = divided ? '0 : src_q + pcg_pkg::SRC_DIV_W'(1);
			if (divided) begin
				if (cfg.bypass_mode) begin
					phase_d = ~phase_q;
				end else begin
					pre_d = scaled ? '0 : pre_q + pcg_pkg::PRESCALE_WIDTH'(1);
					if (scaled) begin
						per_cnt_d = wrap ? '0 : nxt[pcg_pkg::COUNT_WIDTH-1:0];
						result.period_start = wrap;
					end
				end
			end
		end

		// active count clamped to period minus one
		act     = pcg_pkg::COUNT_WIDTH'(cfg.active_len);
		act_eff = (pcg_pkg::CMP_W'(act) > per_m1) ? per_m1[pcg_pkg::COUNT_WIDTH-1:0] : act;

		priority if (!run) begin
			result.pwm_level = ~cfg.active_high;
		end else if (cfg.bypass_mode) begin
			result.pwm_level = phase_d;
		end else if (per_cnt_d < act_eff) begin
			result.pwm_level = cfg.active_high;
		end else begin
			result.pwm_level = ~cfg.active_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q     <= '0;
			pre_q     <= '0;
			per_cnt_q <= '0;
			phase_q   <= 1'b0;
		end else begin
			src_q     <= src_d;
			pre_q     <= pre_d;
			per_cnt_q <= per_cnt_d;
			phase_q   <= phase_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/pcg_out_reg.sv @@
`default_nettype none

// Result register: holds one item until the sink takes it.
module pcg_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire pcg_pkg::pcg_result_t in_result,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output pcg_pkg::pcg_result_t      out_result
);

	logic                 valid_q;
	pcg_pkg::pcg_result_t result_q;

	assign in_ready   = ~valid_q | out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_q <= in_result;
		end
	end

endmodule

`default_nettype wire

@@ hdl/pwm_channel_generator_unit.sv @@
// One PWM channel driven by a stream of source clock ticks. Every accepted item on
// the slave side holds a tick bit in tdata[0] and yields exactly one result item
// with the pin level after it and a flag marking the wrap of the period counter.
// Items are taken one per cycle unless the result stream stalls: counter update
// and level decision sit in one combinational pass in front of a single result
// register, taking a new item when it is empty or drained in the same cycle. The
// user must write registers via the plain write port (cfg_we, cfg_index, cfg_data)
// only while no item is in flight; the block does not enforce this.
`default_nettype none

module pwm_channel_generator_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write port
	input  wire logic                             cfg_we,
	input  wire logic [pcg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [pcg_pkg::CFG_DATA_W-1:0]   cfg_data,
	// tick stream
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [pcg_pkg::STREAM_W-1:0]     s_axis_tdata,  // [0] tick
	// result stream
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [pcg_pkg::STREAM_W-1:0]          m_axis_tdata   // [0] pwm_level, [1] period_start
);

	pcg_pkg::pcg_cfg_t    cfg_q;
	pcg_pkg::pcg_result_t core_result;
	pcg_pkg::pcg_result_t out_result;
	logic                 accept;

	// Register file; period resets to one, everything else to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.div_m_log2     <= '0;
			cfg_q.prescale_k     <= '0;
			cfg_q.bypass_mode    <= 1'b0;
			cfg_q.period_cycles  <= pcg_pkg::PERIOD_CFG_W'(1);
			cfg_q.active_len     <= '0;
			cfg_q.active_high    <= 1'b0;
			cfg_q.channel_enable <= 1'b0;
			cfg_q.clock_gate     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcg_pkg::REG_DIV_M_LOG2:     cfg_q.div_m_log2     <= cfg_data[pcg_pkg::DIV_LOG2_W-1:0];
				pcg_pkg::REG_PRESCALE_K:     cfg_q.prescale_k     <= cfg_data[pcg_pkg::PRESCALE_K_W-1:0];
				pcg_pkg::REG_BYPASS_MODE:    cfg_q.bypass_mode    <= cfg_data[0];
				pcg_pkg::REG_PERIOD_CYCLES:  cfg_q.period_cycles  <= cfg_data[pcg_pkg::PERIOD_CFG_W-1:0];
				pcg_pkg::REG_ACTIVE_LEN:     cfg_q.active_len     <= cfg_data[pcg_pkg::ACTIVE_CFG_W-1:0];
				pcg_pkg::REG_ACTIVE_HIGH:    cfg_q.active_high    <= cfg_data[0];
				pcg_pkg::REG_CHANNEL_ENABLE: cfg_q.channel_enable <= cfg_data[0];
				pcg_pkg::REG_CLOCK_GATE:     cfg_q.clock_gate     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// An item enters when the result register can take its result
	assign accept = s_axis_tvalid & s_axis_tready;

	pcg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.tick   (s_axis_tdata[0]),
		.result (core_result)
	);

	pcg_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_result  (core_result),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (out_result)
	);

	// Pack the result fields, lowest first, pad with zeros
	assign m_axis_tdata = {{(pcg_pkg::STREAM_W-2){1'b0}}, out_result.period_start,
		out_result.pwm_level};

endmodule

`default_nettype wire

@@ hdl/pcg_checker.sv @@
`default_nettype none

module pcg_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [pcg_pkg::STREAM_W-1:0]    m_axis_tdata
);

	// every accepted item leaves a result waiting in the next cycle
	a_item_yields_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted item produced no result");

	// input stalls only while a result is stuck
	a_ready_only_blocked_by_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled with output free");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// no result without an item taken in the cycle before
	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("result appeared without an item");

	// padding bits stay clear
	a_padding_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[pcg_pkg::STREAM_W-1:2] == '0)
		else $error("result padding not zero");

endmodule

bind pwm_channel_generator_unit pcg_checker u_pcg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
